### sv/ldq_pkg.sv
// ldq_pkg: shared types and constants of the leak detect qualifier
// transaction structs, command and status codes, register indexes, reset values
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ldq_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int SENSOR_W   = 6;
	localparam int TICKS_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// sensors actually wired to the field; higher bits are ignored
	localparam int NUM_SENSORS = 6;
	localparam logic [SENSOR_W-1:0] SENSOR_MASK = SENSOR_W'((1 << NUM_SENSORS) - 1);

	localparam logic [SAMPLE_W-1:0] WINDOW_LOW_RST  = 12'd11;
	localparam logic [SAMPLE_W-1:0] WINDOW_HIGH_RST = 12'd3000;
	localparam logic [TICKS_W-1:0]  HAZARD_TICKS_RST = 8'd2;
	localparam logic [TICKS_W-1:0]  COUNT_MAX        = 8'hFF;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HAZARD_TICKS = 2'd2;

	typedef enum logic [1:0] {
		CMD_SAMPLE   = 2'd0,
		CMD_HAZARD   = 2'd1,
		CMD_CRITICAL = 2'd2,
		CMD_STATUS   = 2'd3
	} ldq_cmd_t;

	localparam logic [1:0] STATUS_DRY      = 2'd0;
	localparam logic [1:0] STATUS_HAZARD   = 2'd1;
	localparam logic [1:0] STATUS_CRITICAL = 2'd2;

	typedef struct packed {
		logic [1:0]          command;
		logic [SAMPLE_W-1:0] adc_sample;
		logic [SENSOR_W-1:0] sensor_bits;
	} ldq_in_t;

	typedef struct packed {
		logic [1:0] status_code;
		logic       critical_active;
		logic       hazard_active;
		logic       dry_active;
	} ldq_out_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] window_low;
		logic [SAMPLE_W-1:0] window_high;
		logic [TICKS_W-1:0]  hazard_ticks;
	} ldq_cfg_t;

endpackage

`default_nettype wire

### sv/ldq_cfg_regs.sv
// ldq_cfg_regs: window and hazard threshold configuration registers
// depends on ldq_pkg
`timescale 1ns / 1ps
`default_nettype none

module ldq_cfg_regs
	import ldq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output ldq_cfg_t                   cfg
);

	ldq_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_low   <= WINDOW_LOW_RST;
			cfg_q.window_high  <= WINDOW_HIGH_RST;
			cfg_q.hazard_ticks <= HAZARD_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_LOW:   cfg_q.window_low   <= cfg_wdata[SAMPLE_W-1:0];
				REG_WINDOW_HIGH:  cfg_q.window_high  <= cfg_wdata[SAMPLE_W-1:0];
				REG_HAZARD_TICKS: cfg_q.hazard_ticks <= cfg_wdata[TICKS_W-1:0];
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### sv/ldq_core.sv
// ldq_core: qualifier state and its single-pass update for one transaction
// depends on ldq_pkg; configuration comes from ldq_cfg_regs
`timescale 1ns / 1ps
`default_nettype none

module ldq_core
	import ldq_pkg::*;
#(
	parameter int NUM_CHANNELS = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ldq_cfg_t cfg,
	input  wire logic     update,
	input  wire ldq_in_t  item,
	output ldq_out_t      result
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

	logic [CH_W-1:0]         ptr_q, ptr_d;
	logic [NUM_CHANNELS-1:0] wet_q, wet_d;
	logic [NUM_CHANNELS-1:0] prev_q, prev_d;
	logic                    crit_q, crit_d;
	logic                    hazard_q, hazard_d;
	logic                    dry_q, dry_d;
	logic [TICKS_W-1:0]      count_q, count_d;
	logic                    in_window;
	logic                    any_wet_sensor;

	assign in_window = (item.adc_sample < cfg.window_high) &&
		(item.adc_sample > cfg.window_low);
	assign any_wet_sensor = (item.sensor_bits & SENSOR_MASK) != SENSOR_MASK;

	always_comb begin
		ptr_d    = ptr_q;
		wet_d    = wet_q;
		prev_d   = prev_q;
		crit_d   = crit_q;
		hazard_d = hazard_q;
		dry_d    = dry_q;
		count_d  = count_q;
		case (item.command)
			CMD_SAMPLE: begin
				wet_d[ptr_q] = in_window;
				ptr_d = (ptr_q == CH_LAST) ? '0 : ptr_q + 1'b1;
			end
			CMD_HAZARD: begin
				if (any_wet_sensor) begin
					count_d = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
					if (count_d >= cfg.hazard_ticks) begin
						hazard_d = 1'b1;
						dry_d    = 1'b0;
					end
				end else begin
					count_d  = '0;
					hazard_d = 1'b0;
					dry_d    = 1'b1;
				end
			end
			CMD_CRITICAL: begin
				// wet now and at the previous tick latches for good
				if (|(wet_q & prev_q))
					crit_d = 1'b1;
				prev_d = wet_q;
			end
			default: begin
				// status read leaves state alone
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			wet_q    <= '0;
			prev_q   <= '0;
			crit_q   <= 1'b0;
			hazard_q <= 1'b0;
			dry_q    <= 1'b1;
			count_q  <= '0;
		end else if (update) begin
			ptr_q    <= ptr_d;
			wet_q    <= wet_d;
			prev_q   <= prev_d;
			crit_q   <= crit_d;
			hazard_q <= hazard_d;
			dry_q    <= dry_d;
			count_q  <= count_d;
		end
	end

	always_comb begin
		if (crit_d)
			result.status_code = STATUS_CRITICAL;
		else if (hazard_d)
			result.status_code = STATUS_HAZARD;
		else
			result.status_code = STATUS_DRY;
		result.critical_active = crit_d;
		result.hazard_active   = hazard_d;
		result.dry_active      = dry_d;
	end

	a_crit_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(crit_q))
		else $error("critical latch released");

	a_hazard_dry_excl: assert property (@(posedge clk) disable iff (!arst_n)
		hazard_q != dry_q)
		else $error("hazard and dry flags not complementary");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= CH_LAST)
		else $error("channel pointer out of range");

endmodule

`default_nettype wire

### sv/leak_detect_qualifier.sv
// leak_detect_qualifier: an accepted transaction is captured in the input register, and its result
// is loaded into the result register when stage 1 advances, then held there until taken
// throughput one transaction per cycle, set by the input register feeding the
// state update and result register; a stalled result holds the input stage
// reset: windows 11..3000, hazard threshold 2, all flags clear except dry,
// channel pointer at the first channel, both pipeline stages empty
`timescale 1ns / 1ps
`default_nettype none

module leak_detect_qualifier
	import ldq_pkg::*;
#(
	parameter int NUM_CHANNELS = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input transactions
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire ldq_in_t               in_data,
	// result transactions
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output ldq_out_t                   out_data,
	// configuration write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	ldq_cfg_t cfg;

	// stage 1: captured input transaction
	logic    in_valid_s1;
	ldq_in_t in_data_s1;

	// stage 2: result register
	logic     out_valid_s2;
	ldq_out_t out_data_s2;

	ldq_out_t result;
	logic     advance;

	// stage 1 moves on whenever the result register is free or being drained;
	// the qualifier state is updated in the same cycle, keeping order
	assign advance  = in_valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !in_valid_s1 || advance;

	ldq_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ldq_core #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.update (advance),
		.item   (in_data_s1),
		.result (result)
	);

	// input register: control reset, payload loads on acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			in_data_s1 <= in_data;
	end

	// result register: the status after the transaction, held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_data_s2 <= result;
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

endmodule

`default_nettype wire

### test/testbench.sv
// testbench for leak_detect_qualifier: directed and random command transactions
// against a cycle-free predictor of the qualifier state, with random idling on both sides
// depends on ldq_pkg and leak_detect_qualifier
`timescale 1ns / 1ps

module testbench;
	import ldq_pkg::*;

	localparam int CHANNELS = 4;
	// index past the last register, writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	ldq_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ldq_out_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// predictor copy of the configuration
	logic [SAMPLE_W-1:0] window_lo = WINDOW_LOW_RST;
	logic [SAMPLE_W-1:0] window_hi = WINDOW_HIGH_RST;
	logic [TICKS_W-1:0] haz_thresh = HAZARD_TICKS_RST;

	// predictor copy of the qualifier state
	int unsigned chan_ptr = 0;
	logic [CHANNELS-1:0] wet_now = '0;
	logic [CHANNELS-1:0] wet_prev = '0;
	logic crit_latched = 1'b0;
	logic hazard_on = 1'b0;
	logic dry_on = 1'b1;
	logic [TICKS_W-1:0] wet_ticks = '0;

	// command transactions waiting to be sent, status results still owed by the block
	ldq_in_t cmd_q[$];
	ldq_out_t status_q[$];

	int unsigned mismatch_cnt = 0;
	int unsigned result_cnt = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned issue_cnt = 0;
	bit tx_gaps_on = 1'b1;
	bit rx_stalls_on = 1'b1;

	leak_detect_qualifier #(
		.NUM_CHANNELS(CHANNELS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// advance the qualifier state by one command and return the status it reports
	function automatic ldq_out_t qualify_item(ldq_in_t item);
		ldq_out_t res;
		case (ldq_cmd_t'(item.command))
			CMD_SAMPLE: begin
				// wet only strictly inside the window
				wet_now[chan_ptr] = (item.adc_sample > window_lo) &&
					(item.adc_sample < window_hi);
				chan_ptr = (chan_ptr == CHANNELS - 1) ? 0 : chan_ptr + 1;
			end
			CMD_HAZARD: begin
				if ((item.sensor_bits & SENSOR_MASK) != SENSOR_MASK) begin
					// any low sensor bit is water; count saturates
					if (wet_ticks != COUNT_MAX)
						wet_ticks = wet_ticks + 1'b1;
					if (wet_ticks >= haz_thresh) begin
						hazard_on = 1'b1;
						dry_on = 1'b0;
					end
				end else begin
					wet_ticks = '0;
					hazard_on = 1'b0;
					dry_on = 1'b1;
				end
			end
			CMD_CRITICAL: begin
				// wet on two critical ticks in a row latches for good
				if ((wet_now & wet_prev) != '0)
					crit_latched = 1'b1;
				wet_prev = wet_now;
			end
			default: begin
			end
		endcase
		if (crit_latched)
			res.status_code = STATUS_CRITICAL;
		else if (hazard_on)
			res.status_code = STATUS_HAZARD;
		else
			res.status_code = STATUS_DRY;
		res.critical_active = crit_latched;
		res.hazard_active = hazard_on;
		res.dry_active = dry_on;
		return res;
	endfunction

	function automatic ldq_in_t make_cmd(ldq_cmd_t c, logic [SAMPLE_W-1:0] sample,
			logic [SENSOR_W-1:0] bits);
		ldq_in_t item;
		item.command = c;
		item.adc_sample = sample;
		item.sensor_bits = bits;
		return item;
	endfunction

	// random command; samples often sit on the window edges, sensor ticks are mostly wet
	function automatic ldq_in_t random_cmd(bit sensor_heavy);
		ldq_in_t item;
		int unsigned r;
		item.adc_sample = SAMPLE_W'($urandom_range(0, 4095));
		item.sensor_bits = SENSOR_W'($urandom_range(0, 63));
		r = $urandom_range(0, 99);
		if (r < (sensor_heavy ? 20 : 40)) begin
			item.command = CMD_SAMPLE;
			case ($urandom_range(0, 5))
				0: item.adc_sample = window_lo;
				1: item.adc_sample = window_lo + 1'b1;
				2: item.adc_sample = window_hi - 1'b1;
				3: item.adc_sample = window_hi;
				default: begin
				end
			endcase
		end else if (r < 75) begin
			item.command = CMD_HAZARD;
			case ($urandom_range(0, 4))
				0: item.sensor_bits = SENSOR_MASK;
				1: begin
				end
				default: item.sensor_bits = item.sensor_bits &
					~(SENSOR_W'(1) << $urandom_range(0, SENSOR_W - 1));
			endcase
		end else if (r < 90) begin
			item.command = CMD_CRITICAL;
		end else begin
			item.command = CMD_STATUS;
		end
		return item;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 40);
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (mismatch_cnt < 40)
			$display("result %0d %s: got %0d, expected %0d", result_cnt, what, got, want);
		mismatch_cnt++;
	endtask

	// register write at one edge; the predictor follows the same masking as the block
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_WINDOW_LOW: window_lo = data[SAMPLE_W-1:0];
			REG_WINDOW_HIGH: window_hi = data[SAMPLE_W-1:0];
			REG_HAZARD_TICKS: haz_thresh = data[TICKS_W-1:0];
			default: begin
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// block is idle once nothing is queued, nothing is offered and nothing is owed
	task automatic wait_idle();
		while (cmd_q.size() != 0 || in_valid || status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// driver: predict on each accepted transaction, then offer the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				status_q.push_back(qualify_item(in_data));
			// payload may only change once the current transaction is taken
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if ((issue_cnt % 37) == 36 && status_q.size() != 0) begin
					// periodic hold until every owed result has come back
					in_valid <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					in_data <= cmd_q.pop_front();
					in_valid <= 1'b1;
					gap_left <= tx_gaps_on ? idle_len() : 0;
					issue_cnt <= issue_cnt + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each accepted result with the oldest prediction, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					report_mismatch("unexpected transaction, code", out_data.status_code, 0);
				end else begin
					ldq_out_t want;
					want = status_q.pop_front();
					if (out_data.status_code !== want.status_code)
						report_mismatch("status_code", out_data.status_code, want.status_code);
					if (out_data.critical_active !== want.critical_active)
						report_mismatch("critical_active", out_data.critical_active,
							want.critical_active);
					if (out_data.hazard_active !== want.hazard_active)
						report_mismatch("hazard_active", out_data.hazard_active,
							want.hazard_active);
					if (out_data.dry_active !== want.dry_active)
						report_mismatch("dry_active", out_data.dry_active, want.dry_active);
				end
				result_cnt <= result_cnt + 1;
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				if (rx_stalls_on && $urandom_range(0, 3) == 0)
					stall_left <= idle_len();
			end
		end
	end

	initial begin
		int i;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed at reset settings: status read, hazard counting up to the threshold
		// and clearing, window edges on every channel, critical ticks that must not latch
		cmd_q.push_back(make_cmd(CMD_STATUS, 12'hFFF, 6'h00));
		cmd_q.push_back(make_cmd(CMD_HAZARD, 12'h000, 6'h3F));
		cmd_q.push_back(make_cmd(CMD_HAZARD, 12'hFFF, 6'h00));
		cmd_q.push_back(make_cmd(CMD_HAZARD, 12'h000, 6'h3E));
		cmd_q.push_back(make_cmd(CMD_STATUS, 12'h000, 6'h3F));
		cmd_q.push_back(make_cmd(CMD_HAZARD, 12'h000, 6'h1F));
		cmd_q.push_back(make_cmd(CMD_HAZARD, 12'hFFF, 6'h3F));
		cmd_q.push_back(make_cmd(CMD_HAZARD, 12'h000, 6'h20));
		cmd_q.push_back(make_cmd(CMD_HAZARD, 12'h000, 6'h3F));
		cmd_q.push_back(make_cmd(CMD_SAMPLE, 12'd12, 6'h3F));
		cmd_q.push_back(make_cmd(CMD_SAMPLE, 12'd11, 6'h00));
		cmd_q.push_back(make_cmd(CMD_SAMPLE, 12'd2999, 6'h3F));
		cmd_q.push_back(make_cmd(CMD_SAMPLE, 12'd3000, 6'h00));
		cmd_q.push_back(make_cmd(CMD_CRITICAL, 12'hFFF, 6'h00));
		cmd_q.push_back(make_cmd(CMD_SAMPLE, 12'd0, 6'h3F));
		cmd_q.push_back(make_cmd(CMD_SAMPLE, 12'd4095, 6'h00));
		cmd_q.push_back(make_cmd(CMD_SAMPLE, 12'd10, 6'h3F));
		cmd_q.push_back(make_cmd(CMD_SAMPLE, 12'd3001, 6'h00));
		cmd_q.push_back(make_cmd(CMD_CRITICAL, 12'h000, 6'h3F));
		cmd_q.push_back(make_cmd(CMD_STATUS, 12'h000, 6'h00));
		wait_idle();

		// inverted window never matches, zero threshold trips on the first wet tick,
		// a write to the unused index must change nothing
		write_reg(REG_WINDOW_LOW, 12'hFFF);
		write_reg(REG_WINDOW_HIGH, 12'h000);
		write_reg(REG_HAZARD_TICKS, 12'h000);
		write_reg(REG_NONE, 12'h555);
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b1;
		for (i = 0; i < 80; i++)
			cmd_q.push_back(random_cmd(1'b1));
		wait_idle();

		// narrow window low = high - 1 never matches; threshold 255 via a wide write
		// so only a saturated count asserts hazard
		write_reg(REG_WINDOW_LOW, 12'd2000);
		write_reg(REG_WINDOW_HIGH, 12'd2001);
		write_reg(REG_HAZARD_TICKS, 12'hFFF);
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b0;
		for (i = 0; i < 265; i++) begin
			cmd_q.push_back(make_cmd(CMD_HAZARD, SAMPLE_W'($urandom_range(0, 4095)),
				SENSOR_W'($urandom_range(0, 63)) &
				~(SENSOR_W'(1) << $urandom_range(0, SENSOR_W - 1))));
			if ((i % 50) == 49)
				cmd_q.push_back(random_cmd(1'b0));
		end
		cmd_q.push_back(make_cmd(CMD_HAZARD, 12'h000, 6'h3F));
		for (i = 0; i < 8; i++)
			cmd_q.push_back(random_cmd(1'b1));
		wait_idle();

		// realistic window and small threshold; critical latch expected in here
		write_reg(REG_WINDOW_LOW, CFG_DATA_W'($urandom_range(0, 1500)));
		write_reg(REG_WINDOW_HIGH, CFG_DATA_W'($urandom_range(2500, 4095)));
		write_reg(REG_HAZARD_TICKS, CFG_DATA_W'($urandom_range(1, 8)));
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		for (i = 0; i < 120; i++)
			cmd_q.push_back(random_cmd(1'b0));
		wait_idle();

		// widest window and threshold one, back to back with no random idling on either side
		write_reg(REG_WINDOW_LOW, 12'h000);
		write_reg(REG_WINDOW_HIGH, 12'hFFF);
		write_reg(REG_HAZARD_TICKS, 12'h001);
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		for (i = 0; i < 60; i++)
			cmd_q.push_back(random_cmd(1'b0));
		wait_idle();
		repeat (8) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("PASS leak_detect_qualifier");
		else
			$display("FAIL leak_detect_qualifier");
		$finish;
	end

	// watchdog against a hung handshake or a missing result
	initial begin
		#2_000_000;
		$display("FAIL leak_detect_qualifier");
		$finish;
	end

endmodule

### filelist.f
sv/ldq_pkg.sv
sv/ldq_cfg_regs.sv
sv/ldq_core.sv
sv/leak_detect_qualifier.sv
test/testbench.sv
